FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified concurrent assertion helpers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must hold at every edge while the valid condition is high.
`define ASSERT_WHEN(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

`endif

FILE: hdl/lsd_pkg.sv
// ---------------------------------------------------------------------------
// Laser spot shot detector package
// Field widths, register indexes and the packed beat layouts.
// ---------------------------------------------------------------------------
package lsd_pkg;

	localparam int GREY_W  = 8;
	localparam int COORD_W = 12;
	localparam int SEG_W   = 2;
	localparam int CNT_W   = 8;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 12;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 40;

	localparam logic [CIDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CIDX_W-1:0] REG_BACKOFF   = 3'd1;
	localparam logic [CIDX_W-1:0] REG_AREA_X1   = 3'd2;
	localparam logic [CIDX_W-1:0] REG_AREA_Y1   = 3'd3;
	localparam logic [CIDX_W-1:0] REG_AREA_X2   = 3'd4;
	localparam logic [CIDX_W-1:0] REG_AREA_Y2   = 3'd5;

	localparam logic [GREY_W-1:0] THRESHOLD_RST = 8'd220;
	localparam logic [CNT_W-1:0]  BACKOFF_RST   = 8'd10;

	typedef struct packed {
		logic [SEG_W-1:0]   segment_label;
		logic [COORD_W-1:0] pixel_y;
		logic [COORD_W-1:0] pixel_x;
		logic [GREY_W-1:0]  grey_level;
	} pixel_t;

	typedef struct packed {
		logic [GREY_W-1:0]  peak_level;
		logic [SEG_W-1:0]   spot_segment;
		logic [COORD_W-1:0] spot_y;
		logic [COORD_W-1:0] spot_x;
		logic               target_hit;
		logic               shot_fired;
	} result_t;

	localparam int PIX_W = $bits(pixel_t);
	localparam int RES_W = $bits(result_t);

endpackage

FILE: hdl/laser_spot_shot_detector_unit.sv
// ---------------------------------------------------------------------------
// Laser spot shot detector
// Tracks the brightest pixel of each frame and reports shots and hits.
// ---------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order, one beat per pixel,
// with s_axis_tlast high on the last pixel of a frame. Each frame end
// yields exactly one result beat on the m_axis channel; other pixels yield
// none. Registers are written through the cfg channel, which is always
// ready, and should only be changed while no frame is in flight.
// A pixel is captured in an input register, and from there the peak
// tracker and the shot decision update the state and, on a frame end,
// load the result register, which holds the result beat until the
// receiver takes it. One pixel is taken every cycle; only a frame end
// waits, and only while the result register still holds a beat that the
// receiver has not taken, so a stalled receiver holds the input back by
// at most one frame end. Reset clears both valid flags, empties the
// back-off counter, marks the next pixel as a frame start and loads the
// register reset values (threshold 220, back-off 10, rectangle at zero).
// ---------------------------------------------------------------------------
module laser_spot_shot_detector_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// grey_level, pixel_x, pixel_y, segment_label, zero fill
	input  logic [lsd_pkg::IN_W-1:0]      s_axis_tdata,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// shot_fired, target_hit, spot_x, spot_y, spot_segment, peak_level, zero fill
	output logic [lsd_pkg::OUT_W-1:0]     m_axis_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lsd_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [lsd_pkg::CDATA_W-1:0]   cfg_data
);

	logic [lsd_pkg::GREY_W-1:0]  threshold_q;
	logic [lsd_pkg::CNT_W-1:0]   backoff_frames_q;
	logic [lsd_pkg::COORD_W-1:0] area_x1_q, area_y1_q, area_x2_q, area_y2_q;

	logic                        valid_s1;
	logic                        last_s1;
	lsd_pkg::pixel_t             pix_s1;

	logic [lsd_pkg::GREY_W-1:0]  peak_q;
	logic [lsd_pkg::COORD_W-1:0] peak_x_q, peak_y_q;
	logic [lsd_pkg::SEG_W-1:0]   peak_seg_q;
	logic [lsd_pkg::CNT_W-1:0]   backoff_q;
	logic                        frame_start_q;

	logic                        out_valid_q;
	lsd_pkg::result_t            out_q;

	logic                        out_free;
	logic                        advance;
	logic                        take;
	logic                        replace;
	logic [lsd_pkg::GREY_W-1:0]  new_peak;
	logic [lsd_pkg::COORD_W-1:0] new_x, new_y;
	logic [lsd_pkg::SEG_W-1:0]   new_seg;
	logic [lsd_pkg::COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
	logic                        shot;
	logic                        in_rect;
	logic                        hit;
	logic [lsd_pkg::CNT_W-1:0]   backoff_load;
	logic [lsd_pkg::CNT_W-1:0]   backoff_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q      <= lsd_pkg::THRESHOLD_RST;
			backoff_frames_q <= lsd_pkg::BACKOFF_RST;
			area_x1_q        <= '0;
			area_y1_q        <= '0;
			area_x2_q        <= '0;
			area_y2_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lsd_pkg::REG_THRESHOLD: threshold_q      <= cfg_data[lsd_pkg::GREY_W-1:0];
				lsd_pkg::REG_BACKOFF:   backoff_frames_q <= cfg_data[lsd_pkg::CNT_W-1:0];
				lsd_pkg::REG_AREA_X1:   area_x1_q        <= cfg_data;
				lsd_pkg::REG_AREA_Y1:   area_y1_q        <= cfg_data;
				lsd_pkg::REG_AREA_X2:   area_x2_q        <= cfg_data;
				lsd_pkg::REG_AREA_Y2:   area_y2_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = !valid_s1 || !last_s1 || out_free;
	assign s_axis_tready = advance;
	assign take          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_axis_tvalid) begin
			pix_s1  <= s_axis_tdata[lsd_pkg::PIX_W-1:0];
			last_s1 <= s_axis_tlast;
		end
	end

	assign replace  = frame_start_q || (pix_s1.grey_level > peak_q);
	assign new_peak = replace ? pix_s1.grey_level    : peak_q;
	assign new_x    = replace ? pix_s1.pixel_x       : peak_x_q;
	assign new_y    = replace ? pix_s1.pixel_y       : peak_y_q;
	assign new_seg  = replace ? pix_s1.segment_label : peak_seg_q;

	assign x_lo = (area_x1_q < area_x2_q) ? area_x1_q : area_x2_q;
	assign x_hi = (area_x1_q < area_x2_q) ? area_x2_q : area_x1_q;
	assign y_lo = (area_y1_q < area_y2_q) ? area_y1_q : area_y2_q;
	assign y_hi = (area_y1_q < area_y2_q) ? area_y2_q : area_y1_q;

	assign shot    = (new_peak > threshold_q) && (backoff_q == '0);
	assign in_rect = (new_x >= x_lo) && (new_x <= x_hi) && (new_y >= y_lo) && (new_y <= y_hi);
	assign hit     = shot && (in_rect || (new_seg != '0));

	always_comb begin
		backoff_load = shot ? backoff_frames_q : backoff_q;
		if (backoff_load != '0) begin
			backoff_next = backoff_load - 1'b1;
		end else begin
			backoff_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q <= 1'b1;
			backoff_q     <= '0;
		end else if (take) begin
			frame_start_q <= last_s1;
			if (last_s1) begin
				backoff_q <= backoff_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			peak_q     <= new_peak;
			peak_x_q   <= new_x;
			peak_y_q   <= new_y;
			peak_seg_q <= new_seg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= take && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_s1) begin
			out_q.shot_fired   <= shot;
			out_q.target_hit   <= hit;
			out_q.spot_x       <= new_x;
			out_q.spot_y       <= new_y;
			out_q.spot_segment <= new_seg;
			out_q.peak_level   <= new_peak;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(lsd_pkg::OUT_W-lsd_pkg::RES_W){1'b0}}, out_q};

endmodule

FILE: hdl/lsd_checker.sv
// ---------------------------------------------------------------------------
// Laser spot shot detector checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lsd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      s_axis_tlast,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [lsd_pkg::OUT_W-1:0] m_axis_tdata
);

	logic in_last_beat;

	assign in_last_beat = s_axis_tvalid && s_axis_tready && s_axis_tlast;

	// A stalled result beat keeps its contents.
	`ASSERT_CLK(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

	// A hit is only ever reported together with a shot.
	`ASSERT_WHEN(a_hit_needs_shot, clk, arst_n, m_axis_tvalid, !(m_axis_tdata[1] && !m_axis_tdata[0]), "hit reported without shot")

	// A result beat that appears on an idle channel follows a frame end that has passed the input and result registers.
	`ASSERT_WHEN(a_result_after_end, clk, arst_n, $rose(m_axis_tvalid), $past(in_last_beat, 2), "result without a frame end")

endmodule

bind laser_spot_shot_detector_unit lsd_checker u_lsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
